// File: hw/rtl/tensor_line_dwt_analysis_core_assert.svh
// assertion macros for the wavelet analysis core
`ifndef TENSOR_LINE_DWT_ANALYSIS_CORE_ASSERT_SVH
`define TENSOR_LINE_DWT_ANALYSIS_CORE_ASSERT_SVH
// implication checked every clock outside reset
`define TLD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define TLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: hw/rtl/tld_pkg.sv
// package with constants, types and helpers for the wavelet analysis core
package tld_pkg;
    localparam int MAX_LINE = 64;
    localparam int MAX_TAPS = 8;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS = 16;
    localparam int NCOMP = 9;
    localparam int OUT_BITS = 18;
    localparam int FRAC = COEF_BITS - 2;
    localparam int CNT_W = $clog2(MAX_LINE + 1);
    localparam int POS_W = $clog2(MAX_LINE);
    localparam int TAP_W = $clog2(MAX_TAPS);
    localparam int ROW_W = NCOMP * SAMPLE_BITS;
    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W = PROD_W + TAP_W + 1;

    localparam logic [2:0] REG_LOW_TAPS = 3'd0;
    localparam logic [2:0] REG_HIGH_TAPS = 3'd1;
    localparam logic [2:0] REG_LOW_C0 = 3'd2;
    localparam logic [2:0] REG_LOW_C1 = 3'd3;
    localparam logic [2:0] REG_HIGH_C0 = 3'd4;
    localparam logic [2:0] REG_HIGH_C1 = 3'd5;

    typedef enum logic [1:0] {ST_LOAD, ST_READ, ST_MAC, ST_OUT} state_t;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [OUT_BITS-1:0] coef_out_t;

    function automatic logic [3:0] clamp_taps(input logic [3:0] n);
        logic [3:0] r;
        r = n;
        if (n < 4'd2) r = 4'd2;
        if (n > 4'(MAX_TAPS)) r = 4'(MAX_TAPS);
        return r;
    endfunction

    function automatic coef_out_t finish(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] r;
        r = (acc + (ACC_W)'(1 << (FRAC - 1))) >>> FRAC;
        if (r > (ACC_W)'((1 << (OUT_BITS - 1)) - 1)) return coef_out_t'((1 << (OUT_BITS - 1)) - 1);
        if (r < -(ACC_W)'(1 << (OUT_BITS - 1))) return coef_out_t'(-(1 << (OUT_BITS - 1)));
        return coef_out_t'(r);
    endfunction
endpackage

// File: hw/rtl/tld_if.sv
// valid/ready channel interfaces for samples and coefficients
interface tld_in_if;
    logic valid;
    logic ready;
    logic signed [15:0] comp_xx, comp_xy, comp_xz, comp_yx, comp_yy, comp_yz;
    logic signed [15:0] comp_zx, comp_zy, comp_zz;
    logic line_end;
    modport source (output valid, comp_xx, comp_xy, comp_xz, comp_yx, comp_yy, comp_yz,
        comp_zx, comp_zy, comp_zz, line_end, input ready);
    modport sink (input valid, comp_xx, comp_xy, comp_xz, comp_yx, comp_yy, comp_yz,
        comp_zx, comp_zy, comp_zz, line_end, output ready);
endinterface

interface tld_out_if;
    logic valid;
    logic ready;
    logic signed [17:0] coef_xx, coef_xy, coef_xz, coef_yx, coef_yy, coef_yz;
    logic signed [17:0] coef_zx, coef_zy, coef_zz;
    logic band;
    logic [4:0] coef_index;
    logic run_end;
    modport source (output valid, coef_xx, coef_xy, coef_xz, coef_yx, coef_yy, coef_yz,
        coef_zx, coef_zy, coef_zz, band, coef_index, run_end, input ready);
    modport sink (input valid, coef_xx, coef_xy, coef_xz, coef_yx, coef_yy, coef_yz,
        coef_zx, coef_zy, coef_zz, band, coef_index, run_end, output ready);
endinterface

// File: hw/rtl/tld_ram.sv
// generic single-port-write ram with registered read
module tld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hw/rtl/tld_mac.sv
// nine-lane multiply-accumulate with rounding and saturation
module tld_mac (
    input  logic                                    clk,
    input  logic                                    clr,
    input  logic                                    en,
    input  logic                                    zero,
    input  logic signed [tld_pkg::COEF_BITS-1:0]    tap,
    input  logic [tld_pkg::ROW_W-1:0]               row,
    output tld_pkg::coef_out_t                      res [tld_pkg::NCOMP]
);
    logic signed [tld_pkg::ACC_W-1:0] acc_reg [tld_pkg::NCOMP];

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < tld_pkg::NCOMP; c++)
        begin
            if (clr)
            begin
                acc_reg[c] <= '0;
            end
            else if (en && !zero)
            begin
                acc_reg[c] <= acc_reg[c] + tld_pkg::ACC_W'(tap *
                    $signed(row[c*tld_pkg::SAMPLE_BITS +: tld_pkg::SAMPLE_BITS]));
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < tld_pkg::NCOMP; c++)
        begin
            res[c] = tld_pkg::finish(acc_reg[c]);
        end
    end
endmodule

// File: hw/rtl/tensor_line_dwt_analysis_core.sv
// top level of the line wavelet analysis core
// load: one cycle per sample, written to the line memory
// emit: each coefficient does one memory read per tap, then a drain state, then output
// a line is loaded in full before its coefficients are emitted; memory read port sets the rate
// first coefficient is offered in the output state, after the read and drain states that follow the last sample
// reset: async active low; taps 2, coefficients 0, line empty; memory not cleared
module tensor_line_dwt_analysis_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    tld_in_if.sink      in_ch,
    tld_out_if.source   out_ch
);
    logic [3:0] low_taps_reg, high_taps_reg;
    logic [63:0] lc0_reg, lc1_reg, hc0_reg, hc1_reg;
    tld_pkg::state_t state_reg, state_next;
    logic [tld_pkg::CNT_W-1:0] count_reg, count_next;
    logic [tld_pkg::CNT_W:0] emit_reg, emit_next;
    logic [3:0] m_reg, m_next;
    logic pend_reg, pend_next, pzero_reg, pzero_next;
    logic [3:0] pm_reg, pm_next;
    logic clr;
    logic [tld_pkg::CNT_W-1:0] len, half;
    logic band;
    logic [tld_pkg::CNT_W-1:0] idx;
    logic [3:0] ntaps, ctr;
    logic [tld_pkg::CNT_W+1:0] base;
    logic [tld_pkg::CNT_W-1:0] pos, pos_reg, pos_next;
    logic [tld_pkg::POS_W-1:0] raddr;
    logic rzero;
    logic [63:0] tword;
    logic signed [tld_pkg::COEF_BITS-1:0] tap;
    logic [tld_pkg::ROW_W-1:0] wrow, rrow;
    logic we;
    tld_pkg::coef_out_t res [tld_pkg::NCOMP];
    logic [3:0] nh, ng;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_taps_reg <= 4'd2;
            high_taps_reg <= 4'd2;
            lc0_reg <= '0;
            lc1_reg <= '0;
            hc0_reg <= '0;
            hc1_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tld_pkg::REG_LOW_TAPS: low_taps_reg <= cfg_data[3:0];
                tld_pkg::REG_HIGH_TAPS: high_taps_reg <= cfg_data[3:0];
                tld_pkg::REG_LOW_C0: lc0_reg <= cfg_data;
                tld_pkg::REG_LOW_C1: lc1_reg <= cfg_data;
                tld_pkg::REG_HIGH_C0: hc0_reg <= cfg_data;
                tld_pkg::REG_HIGH_C1: hc1_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign nh = tld_pkg::clamp_taps(low_taps_reg);
    assign ng = tld_pkg::clamp_taps(high_taps_reg);
    assign len = count_reg + tld_pkg::CNT_W'(count_reg[0]);
    assign half = len >> 1;
    assign band = (emit_reg >= {1'b0, half});
    assign idx = band ? tld_pkg::CNT_W'(emit_reg - {1'b0, half})
                      : tld_pkg::CNT_W'(emit_reg);
    assign ntaps = band ? ng : nh;
    assign ctr = band ? ((ng[0] ? ng - 4'd3 : ng - 4'd2) >> 1)
                      : ((nh[0] ? nh - 4'd1 : nh - 4'd2) >> 1);

    // first tap position of the coefficient, wrapped into the line
    always_comb
    begin
        logic [tld_pkg::CNT_W+1:0] b;
        b = (tld_pkg::CNT_W+2)'({idx, 1'b0}) + (tld_pkg::CNT_W+2)'({len, 1'b0})
            - (tld_pkg::CNT_W+2)'(ctr);
        if (b >= (tld_pkg::CNT_W+2)'(len)) b = b - (tld_pkg::CNT_W+2)'(len);
        if (b >= (tld_pkg::CNT_W+2)'(len)) b = b - (tld_pkg::CNT_W+2)'(len);
        base = b;
    end
    assign pos = (m_reg == 4'd0) ? tld_pkg::CNT_W'(base) : pos_reg;
    assign pos_next = (pos + 1'b1 == len) ? '0 : pos + 1'b1;
    assign raddr = tld_pkg::POS_W'(pos);
    assign rzero = (pos >= count_reg);

    assign tword = band ? (pm_reg[2] ? hc1_reg : hc0_reg) : (pm_reg[2] ? lc1_reg : lc0_reg);
    assign tap = tld_pkg::COEF_BITS'(tword >> {pm_reg[1:0], 4'd0});

    assign wrow = {in_ch.comp_zz, in_ch.comp_zy, in_ch.comp_zx, in_ch.comp_yz, in_ch.comp_yy,
                   in_ch.comp_yx, in_ch.comp_xz, in_ch.comp_xy, in_ch.comp_xx};
    assign in_ch.ready = (state_reg == tld_pkg::ST_LOAD);
    assign we = in_ch.valid && in_ch.ready;

    tld_ram #(.WIDTH(tld_pkg::ROW_W), .DEPTH(tld_pkg::MAX_LINE)) u_ram (
        .clk(clk), .we(we), .waddr(tld_pkg::POS_W'(count_reg)), .wdata(wrow),
        .raddr(raddr), .rdata(rrow));

    tld_mac u_mac (
        .clk(clk), .clr(clr), .en(pend_reg), .zero(pzero_reg), .tap(tap),
        .row(rrow), .res(res));

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        emit_next = emit_reg;
        m_next = m_reg;
        pend_next = 1'b0;
        pzero_next = 1'b0;
        pm_next = m_reg;
        clr = 1'b0;
        out_ch.valid = 1'b0;
        case (state_reg)
            tld_pkg::ST_LOAD:
            begin
                if (we)
                begin
                    count_next = count_reg + 1'b1;
                    if (in_ch.line_end || count_reg == tld_pkg::CNT_W'(tld_pkg::MAX_LINE - 1))
                    begin
                        state_next = tld_pkg::ST_READ;
                        emit_next = '0;
                        m_next = '0;
                    end
                end
                clr = 1'b1;
            end
            tld_pkg::ST_READ:
            begin
                pend_next = 1'b1;
                pzero_next = rzero;
                pm_next = m_reg;
                if (m_reg == ntaps - 4'd1)
                begin
                    state_next = tld_pkg::ST_MAC;
                end
                else
                begin
                    m_next = m_reg + 4'd1;
                end
            end
            tld_pkg::ST_MAC:
            begin
                state_next = tld_pkg::ST_OUT;
            end
            tld_pkg::ST_OUT:
            begin
                out_ch.valid = 1'b1;
                if (out_ch.ready)
                begin
                    clr = 1'b1;
                    m_next = '0;
                    if (emit_reg == (tld_pkg::CNT_W+1)'(len) - 1'b1)
                    begin
                        state_next = tld_pkg::ST_LOAD;
                        count_next = '0;
                        emit_next = '0;
                    end
                    else
                    begin
                        emit_next = emit_reg + 1'b1;
                        state_next = tld_pkg::ST_READ;
                    end
                end
            end
            default: state_next = tld_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tld_pkg::ST_LOAD;
            count_reg <= '0;
            emit_reg <= '0;
            m_reg <= '0;
            pend_reg <= 1'b0;
            pzero_reg <= 1'b0;
            pm_reg <= '0;
            pos_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            emit_reg <= emit_next;
            m_reg <= m_next;
            pend_reg <= pend_next;
            pzero_reg <= pzero_next;
            pm_reg <= pm_next;
            pos_reg <= pos_next;
        end
    end

    assign out_ch.coef_xx = res[0];
    assign out_ch.coef_xy = res[1];
    assign out_ch.coef_xz = res[2];
    assign out_ch.coef_yx = res[3];
    assign out_ch.coef_yy = res[4];
    assign out_ch.coef_yz = res[5];
    assign out_ch.coef_zx = res[6];
    assign out_ch.coef_zy = res[7];
    assign out_ch.coef_zz = res[8];
    assign out_ch.band = band;
    assign out_ch.coef_index = idx[4:0];
    assign out_ch.run_end = (emit_reg == (tld_pkg::CNT_W+1)'(len) - 1'b1);
endmodule

// File: hw/rtl/tld_checker.sv
// port-level checker for the wavelet analysis core
`include "tensor_line_dwt_analysis_core_assert.svh"
module tld_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic band,
    input logic run_end,
    input logic [4:0] coef_index
);
    `TLD_ASSERT_IMPL(a_no_overlap, clk, rst_n, out_valid, !in_ready)
    `TLD_ASSERT_IMPL(a_end_high, clk, rst_n, out_valid && run_end, band)
    `TLD_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(coef_index))
    `TLD_ASSERT_NEXT(a_end_load, clk, rst_n, out_valid && out_ready && run_end, in_ready)
endmodule

bind tensor_line_dwt_analysis_core tld_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .band(out_ch.band),
    .run_end(out_ch.run_end), .coef_index(out_ch.coef_index));
